// ===== src/ctgq_pkg.sv =====
// ----------------------------------------------------------------------------
// ctgq_pkg : shared types for the two-color glyph quantizer
// Cell and result word layouts, glyph mode codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ctgq_pkg;

	// glyph mode codes
	localparam logic [2:0] MODE_SEXTANT      = 3'd0;
	localparam logic [2:0] MODE_QUARTER      = 3'd1;
	localparam logic [2:0] MODE_ASCII        = 3'd2;
	localparam logic [2:0] MODE_ASCII_MONO   = 3'd3;
	localparam logic [2:0] MODE_BRAILLE      = 3'd4;
	localparam logic [2:0] MODE_BRAILLE_MONO = 3'd5;

	localparam logic [8:0] BLANK_LIMIT = 9'd40;

	localparam int NPIX = 8;

	typedef struct packed {
		logic [23:0] pixel_0;
		logic [23:0] pixel_1;
		logic [23:0] pixel_2;
		logic [23:0] pixel_3;
		logic [23:0] pixel_4;
		logic [23:0] pixel_5;
		logic [23:0] pixel_6;
		logic [23:0] pixel_7;
	} cell_t;

	typedef struct packed {
		logic [7:0]  glyph_index;
		logic [23:0] fore_color;
		logic [23:0] back_color;
	} result_t;

endpackage

`default_nettype wire

// ===== src/ctgq_dist.sv =====
// ----------------------------------------------------------------------------
// ctgq_dist : pipelined color distance
// floor(sqrt(dr^2 + dg^2 + db^2)), four register stages, no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgq_dist (
	input  wire logic        clk,
	input  wire logic [23:0] a,
	input  wire logic [23:0] b,
	output logic [8:0]       distance
);
	typedef struct packed {
		logic [17:0] rem;
		logic [18:0] root;
	} sq_state_t;

	// one digit of the bit-pair square root; step 0 uses the top pair
	function automatic sq_state_t sqrt_step(sq_state_t s, int j);
		sq_state_t o;
		logic [18:0] bitv;
		logic [18:0] trial;
		bitv  = 19'(1) << (2 * (8 - j));
		trial = s.root + bitv;
		o = s;
		if ({1'b0, s.rem} >= trial) begin
			o.rem  = s.rem - trial[17:0];
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	function automatic sq_state_t sqrt_three(sq_state_t s, int first);
		sq_state_t o;
		o = s;
		for (int j = 0; j < 3; j++) begin
			o = sqrt_step(o, first + j);
		end
		return o;
	endfunction

	logic [17:0] sum_w;
	logic [17:0] sq_s1;
	sq_state_t   st_s2, st_s3, st_last;
	logic [8:0]  dist_s4;

	always_comb begin
		logic [7:0] x, y, d;
		sum_w = '0;
		for (int k = 0; k < 3; k++) begin
			x = a[8*k +: 8];
			y = b[8*k +: 8];
			d = (x > y) ? (x - y) : (y - x);
			sum_w = sum_w + 18'(16'(d) * 16'(d));
		end
	end

	assign st_last = sqrt_three(st_s3, 6);

	always_ff @(posedge clk) begin
		sq_s1   <= sum_w;
		st_s2   <= sqrt_three('{rem: sq_s1, root: '0}, 0);
		st_s3   <= sqrt_three(st_s2, 3);
		dist_s4 <= st_last.root[8:0];
	end

	assign distance = dist_s4;

endmodule

`default_nettype wire

// ===== src/cell_two_color_glyph_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// cell_two_color_glyph_quantizer_top : two-color glyph quantizer
// Picks two colors for a 2-wide cell and maps the pixel mask to a glyph.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a cell word (eight RGB pixels, row-major) is taken at each clock
//   edge with start high and busy low. busy is never raised; a cell may be
//   given in every cycle.
//   Output: each result word is on result for one cycle with done high.
//   The receiver cannot stall, so the pipeline never holds.
//   Throughput: one cell per cycle. The pipeline is made of three passes
//   through the four-stage distance pipe (seed, cluster, mask), one through
//   it for the brightness check, plus selection, summing, a two-stage
//   divider, the swap register and the output register.
//   Config: glyph_mode is written on the cfg channel (cfg_ready always high)
//   and is to be changed only while no cell is in flight.
//   Reset: arst_n low clears the valid line and sets glyph_mode to sextant.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_two_color_glyph_quantizer_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  ctgq_pkg::cell_t      pixels,
	output logic                 done,
	output ctgq_pkg::result_t    result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [2:0]      cfg_data
);
	import ctgq_pkg::*;

	localparam int LAT = 22;

	logic [2:0] mode_q;
	logic       braille, ascii, quarter, mono;
	logic [3:0] npix;
	logic       accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SEXTANT;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign braille = (mode_q == MODE_BRAILLE) || (mode_q == MODE_BRAILLE_MONO);
	assign ascii   = (mode_q == MODE_ASCII) || (mode_q == MODE_ASCII_MONO);
	assign quarter = (mode_q == MODE_QUARTER);
	assign mono    = (mode_q == MODE_ASCII_MONO) || (mode_q == MODE_BRAILLE_MONO);
	assign npix    = braille ? 4'd8 : 4'd6;

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end
	assign done = vld_q[LAT-1];

	// pixel taps; px_q holds delayed copies of the cell, px_q[0] registered from px_in
	logic [NPIX-1:0][23:0] px_in;
	logic [NPIX-1:0][23:0] px_q [0:16];

	assign px_in = {pixels.pixel_7, pixels.pixel_6, pixels.pixel_5, pixels.pixel_4,
			pixels.pixel_3, pixels.pixel_2, pixels.pixel_1, pixels.pixel_0};

	always_ff @(posedge clk) begin
		px_q[0] <= px_in;
		for (int k = 1; k <= 16; k++) begin
			px_q[k] <= px_q[k-1];
		end
	end

	// ---- seed distances to pixel 0
	logic [8:0] da_w [0:NPIX-1];
	logic [8:0] db_w [0:NPIX-1];
	logic [8:0] na_w [0:NPIX-1];
	logic [8:0] nb_w [0:NPIX-1];

	logic [23:0] b_s5;
	logic [8:0]  da_s5 [0:NPIX-1];
	logic [8:0]  da_d_q [0:3][0:NPIX-1];
	logic [23:0] bseed_q [0:5];

	always_ff @(posedge clk) begin
		logic [8:0]  best;
		logic [23:0] bsel;
		best = '0;
		bsel = '0;
		for (int i = 1; i < NPIX; i++) begin
			if (4'(i) < npix && da_w[i] > best) begin
				best = da_w[i];
				bsel = px_q[3][i];
			end
		end
		b_s5 <= bsel;
		da_s5 <= da_w;
		da_d_q[0] <= da_s5;
		for (int k = 1; k < 4; k++) begin
			da_d_q[k] <= da_d_q[k-1];
		end
		bseed_q[0] <= b_s5;
		for (int k = 1; k < 6; k++) begin
			bseed_q[k] <= bseed_q[k-1];
		end
	end

	// ---- cluster sums
	logic [10:0] sum_s10 [0:1][0:2];
	logic [3:0]  cnt_s10 [0:1];

	always_ff @(posedge clk) begin
		logic [10:0] s [0:1][0:2];
		logic [3:0]  c [0:1];
		logic        g;
		for (int h = 0; h < 2; h++) begin
			c[h] = '0;
			for (int k = 0; k < 3; k++) begin
				s[h][k] = '0;
			end
		end
		for (int i = 0; i < NPIX; i++) begin
			if (4'(i) < npix) begin
				g = da_d_q[3][i] > db_w[i];
				c[g] = c[g] + 4'd1;
				for (int k = 0; k < 3; k++) begin
					s[g][k] = s[g][k] + 11'(px_q[8][i][16-8*k +: 8]);
				end
			end
		end
		sum_s10 <= s;
		cnt_s10 <= c;
	end

	// ---- means: restoring divide, quotient bits 7..4 then 3..0
	logic [10:0] rem_s11 [0:1][0:2];
	logic [7:0]  quo_s11 [0:1][0:2];
	logic [3:0]  cnt_s11 [0:1];
	logic [23:0] a_s12, b_s12;

	always_ff @(posedge clk) begin
		logic [10:0] r, dv;
		logic [7:0]  q;
		for (int h = 0; h < 2; h++) begin
			for (int k = 0; k < 3; k++) begin
				r = sum_s10[h][k];
				q = '0;
				for (int j = 7; j >= 4; j--) begin
					dv = 11'(cnt_s10[h]) << j;
					if (r >= dv) begin
						r = r - dv;
						q[j] = 1'b1;
					end
				end
				rem_s11[h][k] <= r;
				quo_s11[h][k] <= q;
			end
		end
		cnt_s11 <= cnt_s10;
	end

	always_ff @(posedge clk) begin
		logic [10:0] r, dv;
		logic [7:0]  q;
		logic [23:0] m [0:1];
		for (int h = 0; h < 2; h++) begin
			for (int k = 0; k < 3; k++) begin
				r = rem_s11[h][k];
				q = quo_s11[h][k];
				for (int j = 3; j >= 0; j--) begin
					dv = 11'(cnt_s11[h]) << j;
					if (r >= dv) begin
						r = r - dv;
						q[j] = 1'b1;
					end
				end
				m[h][16-8*k +: 8] = q;
			end
		end
		// an empty cluster keeps its seed
		a_s12 <= (cnt_s11[0] != '0) ? m[0] : px_q[10][0];
		b_s12 <= (cnt_s11[1] != '0) ? m[1] : bseed_q[5];
	end

	// ---- brightness and swap
	logic [8:0]  d0a_w, d0b_w;
	logic [23:0] a_d_q [0:3];
	logic [23:0] b_d_q [0:3];
	logic [23:0] a_s17, b_s17;
	logic [8:0]  d0a_s17;
	logic [23:0] fa_q [0:3];
	logic [23:0] fb_q [0:3];
	logic [8:0]  fd_q [0:3];

	always_ff @(posedge clk) begin
		logic swap;
		a_d_q[0] <= a_s12;
		b_d_q[0] <= b_s12;
		for (int k = 1; k < 4; k++) begin
			a_d_q[k] <= a_d_q[k-1];
			b_d_q[k] <= b_d_q[k-1];
		end
		swap = (ascii || braille) && (d0b_w > d0a_w);
		a_s17   <= swap ? b_d_q[3] : a_d_q[3];
		b_s17   <= mono ? '0 : (swap ? a_d_q[3] : b_d_q[3]);
		d0a_s17 <= swap ? d0b_w : d0a_w;
		fa_q[0] <= a_s17;
		fb_q[0] <= b_s17;
		fd_q[0] <= d0a_s17;
		for (int k = 1; k < 4; k++) begin
			fa_q[k] <= fa_q[k-1];
			fb_q[k] <= fb_q[k-1];
			fd_q[k] <= fd_q[k-1];
		end
	end

	// ---- mask and glyph
	result_t res_s22;

	always_ff @(posedge clk) begin
		logic [NPIX-1:0] near;
		logic [7:0]      mask;
		logic            full;
		result_t         r;
		for (int i = 0; i < NPIX; i++) begin
			near[i] = na_w[i] < nb_w[i];
		end
		r.fore_color = fa_q[3];
		r.back_color = fb_q[3];
		if (braille) begin
			mask = {near[7], near[6], near[5], near[3], near[1], near[4], near[2], near[0]};
		end else if (quarter) begin
			mask = {4'd0, near[3:0]};
		end else begin
			mask = {2'd0, near[5:0]};
		end
		full = quarter ? (&near[3:0]) : (&near[5:0]);
		if (!braille && full && (!ascii || fd_q[3] < BLANK_LIMIT)) begin
			mask = '0;
			r.fore_color = fb_q[3];
			r.back_color = fa_q[3];
		end
		r.glyph_index = mask;
		res_s22 <= r;
	end

	assign result = res_s22;

	// ---- distance pipes
	for (genvar i = 0; i < NPIX; i++) begin : g_dist
		ctgq_dist u_seed (.clk(clk), .a(px_in[i]),    .b(px_in[0]), .distance(da_w[i]));
		ctgq_dist u_clus (.clk(clk), .a(px_q[4][i]),  .b(b_s5),     .distance(db_w[i]));
		ctgq_dist u_na   (.clk(clk), .a(px_q[16][i]), .b(a_s17),    .distance(na_w[i]));
		ctgq_dist u_nb   (.clk(clk), .a(px_q[16][i]), .b(b_s17),    .distance(nb_w[i]));
	end

	ctgq_dist u_d0a (.clk(clk), .a(a_s12), .b(24'd0), .distance(d0a_w));
	ctgq_dist u_d0b (.clk(clk), .a(b_s12), .b(24'd0), .distance(d0b_w));

	// ---- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##22 done)
		else $error("result word missing after fixed latency");

	a_six_bit: assert property (@(posedge clk) disable iff (!arst_n)
		done && !braille |-> result.glyph_index[7:6] == 2'd0)
		else $error("glyph index out of range for six-bit modes");

	a_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		done && quarter |-> result.glyph_index[7:4] == 4'd0)
		else $error("quarter glyph index out of range");

	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		done && mode_q == MODE_BRAILLE_MONO |-> result.back_color == 24'd0)
		else $error("braille mono background not black");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb : testbench for the two-color glyph quantizer
// Drives cells through every glyph mode, predicts each result word with an
// independent model and checks results in order as they come out.
// ----------------------------------------------------------------------------
`default_nettype none

class glyph_scoreboard;
	ctgq_pkg::result_t pending[$];
	int errors;
	int checked;

	function void note(ctgq_pkg::result_t r);
		pending.push_back(r);
	endfunction

	function void check(ctgq_pkg::result_t got);
		ctgq_pkg::result_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		checked++;
		if (got.glyph_index !== exp_r.glyph_index) begin
			$display("%0t: glyph_index exp %h got %h", $time, exp_r.glyph_index, got.glyph_index);
			errors++;
		end
		if (got.fore_color !== exp_r.fore_color) begin
			$display("%0t: fore_color exp %h got %h", $time, exp_r.fore_color, got.fore_color);
			errors++;
		end
		if (got.back_color !== exp_r.back_color) begin
			$display("%0t: back_color exp %h got %h", $time, exp_r.back_color, got.back_color);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ctgq_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	cell_t pixels = '0;
	logic done;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_data = '0;

	logic [2:0] mode_shadow;
	glyph_scoreboard sb;
	int cells_sent;
	int mode_hits[8];

	cell_two_color_glyph_quantizer_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixels(pixels),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (done)
			sb.check(result);
	end

	function automatic logic [7:0] ch(logic [23:0] c, int k);
		return c[23 - 8 * k -: 8];
	endfunction

	function automatic int unsigned root_floor(int unsigned n);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= n)
			r++;
		return r;
	endfunction

	function automatic int unsigned rgb_dist(logic [23:0] a, logic [23:0] b);
		int unsigned s;
		int d;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			d = int'(ch(a, k)) - int'(ch(b, k));
			s += d * d;
		end
		return root_floor(s);
	endfunction

	function automatic result_t quantize(cell_t c, logic [2:0] m_in);
		logic [23:0] px[8];
		logic [23:0] ca, cb, tmp, fore, back;
		int unsigned best, cnt[2], sums[2][3], npx, bits, nset;
		logic [7:0] mask;
		logic [2:0] m;
		bit braille, ascii;
		int g;
		result_t r;
		m = m_in;
		braille = (m == MODE_BRAILLE || m == MODE_BRAILLE_MONO);
		ascii = (m == MODE_ASCII || m == MODE_ASCII_MONO);
		if (m > MODE_BRAILLE_MONO)
			m = MODE_SEXTANT;
		px = '{c.pixel_0, c.pixel_1, c.pixel_2, c.pixel_3,
			c.pixel_4, c.pixel_5, c.pixel_6, c.pixel_7};
		npx = braille ? 8 : 6;
		ca = px[0];
		cb = '0;
		best = 0;
		for (int i = 1; i < npx; i++) begin
			if (rgb_dist(px[i], ca) > best) begin
				best = rgb_dist(px[i], ca);
				cb = px[i];
			end
		end
		cnt = '{0, 0};
		sums = '{'{0, 0, 0}, '{0, 0, 0}};
		for (int i = 0; i < npx; i++) begin
			g = (rgb_dist(px[i], ca) <= rgb_dist(px[i], cb)) ? 0 : 1;
			cnt[g]++;
			for (int k = 0; k < 3; k++)
				sums[g][k] += ch(px[i], k);
		end
		if (cnt[0] != 0)
			ca = {8'(sums[0][0] / cnt[0]), 8'(sums[0][1] / cnt[0]), 8'(sums[0][2] / cnt[0])};
		if (cnt[1] != 0)
			cb = {8'(sums[1][0] / cnt[1]), 8'(sums[1][1] / cnt[1]), 8'(sums[1][2] / cnt[1])};
		if (ascii || braille) begin
			if (rgb_dist(24'h0, cb) > rgb_dist(24'h0, ca)) begin
				tmp = ca;
				ca = cb;
				cb = tmp;
			end
			if (m == MODE_ASCII_MONO || m == MODE_BRAILLE_MONO)
				cb = '0;
		end
		fore = ca;
		back = cb;
		mask = '0;
		if (braille) begin
			// column-major dot order, row 3 in the top two bits
			int dot_src[8] = '{0, 2, 4, 1, 3, 5, 6, 7};
			for (int i = 0; i < 8; i++)
				mask[i] = rgb_dist(px[dot_src[i]], ca) < rgb_dist(px[dot_src[i]], cb);
		end else begin
			bits = (m == MODE_QUARTER) ? 4 : 6;
			nset = 0;
			for (int i = 0; i < bits; i++) begin
				mask[i] = rgb_dist(px[i], ca) < rgb_dist(px[i], cb);
				nset += mask[i];
			end
			if (nset == bits && (!ascii || rgb_dist(24'h0, ca) < BLANK_LIMIT)) begin
				mask = '0;
				fore = cb;
				back = ca;
			end
		end
		r.glyph_index = mask;
		r.fore_color = fore;
		r.back_color = back;
		return r;
	endfunction

	task automatic set_mode(logic [2:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		mode_shadow = m;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_cell(cell_t c, bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 16) : 0;
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pixels <= c;
		do @(posedge clk); while (busy);
		sb.note(quantize(c, mode_shadow));
		mode_hits[mode_shadow]++;
		cells_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_px(logic [23:0] base);
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'($urandom());
			3: return base ^ 24'($urandom_range(0, 7) << (8 * $urandom_range(0, 2)));
			default: return base;
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		logic [23:0] a, b;
		a = 24'($urandom());
		b = ($urandom_range(0, 2) == 0) ? 24'($urandom()) : ~a;
		if ($urandom_range(0, 4) == 0)
			return cell_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom()});
		c.pixel_0 = rand_px(a);
		c.pixel_1 = rand_px($urandom_range(0, 1) ? a : b);
		c.pixel_2 = rand_px($urandom_range(0, 1) ? a : b);
		c.pixel_3 = rand_px($urandom_range(0, 1) ? a : b);
		c.pixel_4 = rand_px($urandom_range(0, 1) ? a : b);
		c.pixel_5 = rand_px($urandom_range(0, 1) ? a : b);
		c.pixel_6 = rand_px($urandom_range(0, 1) ? a : b);
		c.pixel_7 = rand_px($urandom_range(0, 1) ? a : b);
		return c;
	endfunction

	initial begin
		#2ms;
		$display("tb failed");
		$finish;
	end

	initial begin
		logic [2:0] modes[8] = '{MODE_SEXTANT, MODE_QUARTER, MODE_ASCII, MODE_ASCII_MONO,
			MODE_BRAILLE, MODE_BRAILLE_MONO, 3'd6, 3'd7};
		sb = new();
		mode_shadow = MODE_SEXTANT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: uniform, extremes, blank and dark-blank cases in each mode
		foreach (modes[mi]) begin
			set_mode(modes[mi]);
			send_cell('0, 0);
			send_cell('1, 0);
			send_cell({24'hFFFFFF, {7{24'h000000}}}, 0);
			send_cell({24'h101010, {6{24'h101010}}, 24'hF0F0F0}, 0);
			send_cell({{6{24'h202020}}, 24'hFFFFFF, 24'h000000}, 0);
			send_cell({24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
				24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF}, 0);
			send_cell({24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF0000,
				24'h00FF00, 24'h0000FF, 24'h808080, 24'h7F7F7F}, 1);
			drain();
		end

		// random: phases of random length, the first eight in each mode code in turn, the rest in a random mode
		for (int ph = 0; ph < 16; ph++) begin
			set_mode((ph < 8) ? modes[ph] : 3'($urandom_range(0, 7)));
			repeat ($urandom_range(20, 40))
				send_cell(rand_cell(), $urandom_range(0, 2) != 0);
			drain();
		end
		set_mode(MODE_SEXTANT);

		$display("covered %0d cells, %0d results checked", cells_sent, sb.checked);
		$display("cells per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
			mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
src/ctgq_pkg.sv
src/ctgq_dist.sv
src/cell_two_color_glyph_quantizer_top.sv
bench/tb.sv
